// ===== rtl/core/bptc_pkg.sv =====
package bptc_pkg;

	// Calibration register indexes on the configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PSENS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POFF  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TCS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TCO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TREF  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPSENS = 3'd5;

	localparam int COEFF_W = 16;
	localparam int RAW_W   = 24;
	localparam int TEMP_W  = 19;
	localparam int PRES_W  = 32;

	// Temperature band edges, hundredths of a degree
	localparam logic signed [TEMP_W-1:0] T_REF  = 19'sd2000;
	localparam logic signed [TEMP_W-1:0] T_COLD = -19'sd1500;
	// T_COLD - T_REF, compared against the shifted slope product
	localparam logic signed [17:0] LO_COLD = -18'sd3500;

	// Second-order weights
	localparam logic [40:0] K_OFF2_LO  = 41'd61;
	localparam logic [40:0] K_SENS2_LO = 41'd29;
	localparam logic [39:0] K_OFF2_HI  = 40'd17;
	localparam logic [39:0] K_SENS2_HI = 40'd9;

	// Factory calibration words
	typedef struct packed {
		logic [COEFF_W-1:0] psens;    // C1
		logic [COEFF_W-1:0] poff;     // C2
		logic [COEFF_W-1:0] tcs;      // C3
		logic [COEFF_W-1:0] tco;      // C4
		logic [COEFF_W-1:0] tref;     // C5
		logic [COEFF_W-1:0] tempsens; // C6
	} coeffs_t;

endpackage

// ===== rtl/core/bptc_cfg_regs.sv =====
module bptc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bptc_pkg::COEFF_W-1:0]    cfg_data,
	output bptc_pkg::coeffs_t               coeffs
);
	import bptc_pkg::*;

	coeffs_t coeffs_q;

	// Register file write; unknown indexes drop the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeffs_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PSENS:    coeffs_q.psens    <= cfg_data;
				CFG_POFF:     coeffs_q.poff     <= cfg_data;
				CFG_TCS:      coeffs_q.tcs      <= cfg_data;
				CFG_TCO:      coeffs_q.tco      <= cfg_data;
				CFG_TREF:     coeffs_q.tref     <= cfg_data;
				CFG_TEMPSENS: coeffs_q.tempsens <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coeffs = coeffs_q;

endmodule

// ===== rtl/core/baro_pressure_temp_compensation.sv =====
// Channel   Handshake                 Payload
// sample    sample_valid/stall        raw_pressure, raw_temperature
// result    result_valid/stall        temperature_centi, pressure_centi_mbar
// cfg       cfg_valid/cfg_ready       cfg_index, cfg_data
//
// Nine-stage pipeline: one sample pair per cycle while the result side does not stall.
// The stage count is set by the multiplier stages and the 24x40 pressure product,
// which is split into two partial products with a stage to merge them.
// arst_n clears the valid bits and the calibration registers to zero.
// A stalled result freezes the whole pipeline; sample_stall follows it.
module baro_pressure_temp_compensation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic [bptc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]           raw_temperature,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [bptc_pkg::TEMP_W-1:0]   temperature_centi,
	output logic signed [bptc_pkg::PRES_W-1:0]   pressure_centi_mbar,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bptc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bptc_pkg::COEFF_W-1:0]         cfg_data
);
	import bptc_pkg::*;

	coeffs_t coeffs;

	bptc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coeffs    (coeffs)
	);

	assign cfg_ready = 1'b1;

	// Pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic advance;

	assign advance      = !v_s9 || !result_stall;
	assign sample_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else if (advance) begin
			v_s1 <= sample_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_s7; v_s9 <= v_s8;
		end
	end

	// Stage 1: temperature difference dT
	logic signed [24:0] dt_c;
	assign dt_c = $signed({1'b0, raw_temperature}) - $signed({1'b0, coeffs.tref, 8'h00});

	// Stage 2: products of dT
	logic signed [41:0] tc_c, offl_c, sensl_c;
	logic signed [49:0] dtsq_c;
	// Stage 3: first-order temperature, T2, linear offset and sensitivity
	logic signed [17:0] lo_c;
	logic signed [18:0] temp_c, hi_c;
	logic               warm_c, cold_c;
	logic [49:0]        m3_c;
	logic [50:0]        m5_c;
	logic [16:0]        t2_c;
	logic signed [34:0] off_base_c, sens_base_c;
	// Stage 4: squares and output temperature
	logic signed [35:0] losq_c;
	logic signed [37:0] hisq_c;
	logic signed [18:0] tout_c;
	// Stage 5: second-order offset and sensitivity
	logic [40:0]        lo_off_c, lo_sens_c;
	logic [39:0]        hi_off_c, hi_sens_c;
	logic [39:0]        off2_c, sens2_c;
	// Stage 6: final offset and sensitivity
	logic signed [41:0] off_c, sens_full_c;
	// Stage 7: partial products of D1*SENS
	logic [43:0]        pp_lo_c;
	logic signed [44:0] pp_hi_c;
	// Stage 8: merged product
	logic signed [65:0] prod_c;
	// Stage 9: pressure
	logic signed [42:0] diff_c;

	logic [23:0]        d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [24:0] dt_s1;
	logic signed [41:0] tc_prod_s2, offl_s2, sensl_s2;
	logic [47:0]        dtsq_s2;
	logic signed [17:0] lo_s3;
	logic signed [18:0] hi_s3, temp_s3;
	logic               warm_s3, cold_s3, warm_s4, cold_s4;
	logic [16:0]        t2_s3;
	logic signed [34:0] off_base_s3, sens_base_s3, off_base_s4, sens_base_s4;
	logic signed [34:0] off_base_s5, sens_base_s5;
	logic [34:0]        losq_s4, hisq_s4;
	logic signed [18:0] tout_s4, tout_s5, tout_s6, tout_s7, tout_s8, tout_s9;
	logic [39:0]        off2_s5, sens2_s5;
	logic signed [41:0] off_s6, off_s7, off_s8;
	logic signed [39:0] sens_s6;
	logic [43:0]        pp_lo_s7;
	logic signed [44:0] pp_hi_s7;
	logic signed [41:0] pr_s8;
	logic signed [31:0] pres_s9;

	// Stage 2 multipliers
	assign tc_c    = dt_s1 * $signed({1'b0, coeffs.tempsens});
	assign dtsq_c  = dt_s1 * dt_s1;
	assign offl_c  = dt_s1 * $signed({1'b0, coeffs.tco});
	assign sensl_c = dt_s1 * $signed({1'b0, coeffs.tcs});

	// Stage 3: floor shifts, band decode, T2 selection
	assign lo_c    = tc_prod_s2[40:23];
	assign temp_c  = $signed({lo_c[17], lo_c}) + T_REF;
	assign hi_c    = temp_c - T_COLD;
	assign warm_c  = !lo_c[17];
	assign cold_c  = lo_c < LO_COLD;
	assign m3_c    = {dtsq_s2, 1'b0} + {2'b00, dtsq_s2};
	assign m5_c    = {1'b0, dtsq_s2, 2'b00} + {3'b000, dtsq_s2};
	assign t2_c    = warm_c ? {4'b0000, m5_c[50:38]} : m3_c[49:33];
	assign off_base_c  = $signed({3'b000, coeffs.poff, 16'h0000})
	                   + $signed({offl_s2[40], offl_s2[40:7]});
	assign sens_base_c = $signed({4'b0000, coeffs.psens, 15'h0000})
	                   + $signed({{2{sensl_s2[40]}}, sensl_s2[40:8]});

	// Stage 4: squares of the band distances
	assign losq_c = lo_s3 * lo_s3;
	assign hisq_c = hi_s3 * hi_s3;
	assign tout_c = temp_s3 - $signed({2'b00, t2_s3});

	// Stage 5: weighted second-order terms
	assign lo_off_c  = {6'd0, losq_s4} * K_OFF2_LO;
	assign lo_sens_c = {6'd0, losq_s4} * K_SENS2_LO;
	assign hi_off_c  = {5'd0, hisq_s4} * K_OFF2_HI;
	assign hi_sens_c = {5'd0, hisq_s4} * K_SENS2_HI;

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (!warm_s4) begin
			off2_c  = {3'b000, lo_off_c[40:4]};
			sens2_c = {3'b000, lo_sens_c[40:4]};
			if (cold_s4) begin
				off2_c  = off2_c + hi_off_c;
				sens2_c = sens2_c + hi_sens_c;
			end
		end
	end

	// Stage 6: subtract the corrections
	assign off_c       = $signed({{7{off_base_s5[34]}}, off_base_s5}) - $signed({2'b00, off2_s5});
	assign sens_full_c = $signed({{7{sens_base_s5[34]}}, sens_base_s5})
	                   - $signed({2'b00, sens2_s5});

	// Stage 7: D1*SENS split at bit 20 of SENS
	assign pp_lo_c = d1_s6 * sens_s6[19:0];
	assign pp_hi_c = $signed({1'b0, d1_s6}) * $signed(sens_s6[39:20]);

	// Stage 8: merge partial products
	assign prod_c = $signed({pp_hi_s7, 20'h00000}) + $signed({22'd0, pp_lo_s7});

	// Stage 9: subtract offset, final floor shift
	assign diff_c = $signed({pr_s8[41], pr_s8}) - $signed({off_s8[41], off_s8});

	// Pipeline payload registers
	always_ff @(posedge clk) begin
		if (advance) begin
			d1_s1        <= raw_pressure;
			dt_s1        <= dt_c;

			d1_s2        <= d1_s1;
			tc_prod_s2   <= tc_c;
			dtsq_s2      <= dtsq_c[47:0];
			offl_s2      <= offl_c;
			sensl_s2     <= sensl_c;

			d1_s3        <= d1_s2;
			lo_s3        <= lo_c;
			hi_s3        <= hi_c;
			temp_s3      <= temp_c;
			warm_s3      <= warm_c;
			cold_s3      <= cold_c;
			t2_s3        <= t2_c;
			off_base_s3  <= off_base_c;
			sens_base_s3 <= sens_base_c;

			d1_s4        <= d1_s3;
			losq_s4      <= losq_c[34:0];
			hisq_s4      <= hisq_c[34:0];
			tout_s4      <= tout_c;
			warm_s4      <= warm_s3;
			cold_s4      <= cold_s3;
			off_base_s4  <= off_base_s3;
			sens_base_s4 <= sens_base_s3;

			d1_s5        <= d1_s4;
			off2_s5      <= off2_c;
			sens2_s5     <= sens2_c;
			off_base_s5  <= off_base_s4;
			sens_base_s5 <= sens_base_s4;
			tout_s5      <= tout_s4;

			d1_s6        <= d1_s5;
			off_s6       <= off_c;
			sens_s6      <= sens_full_c[39:0];
			tout_s6      <= tout_s5;

			pp_lo_s7     <= pp_lo_c;
			pp_hi_s7     <= pp_hi_c;
			off_s7       <= off_s6;
			tout_s7      <= tout_s6;

			pr_s8        <= prod_c[62:21];
			off_s8       <= off_s7;
			tout_s8      <= tout_s7;

			pres_s9      <= {{4{diff_c[42]}}, diff_c[42:15]};
			tout_s9      <= tout_s8;
		end
	end

	assign result_valid        = v_s9;
	assign temperature_centi   = tout_s9;
	assign pressure_centi_mbar = pres_s9;

	// An accepted sample lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> v_s1)
		else $error("accepted sample did not enter stage 1");

	// A stall freezes every valid bit
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9}))
		else $error("pipeline moved during a stall");

	// Valid bits shift one stage per advance
	a_valid_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_stall |=> (v_s5 == $past(v_s4) && v_s9 == $past(v_s8)))
		else $error("valid bit lost or duplicated");

	// Warm-band T2 stays within its 13-bit range
	a_t2_warm: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && warm_s3) |-> (t2_s3[16:13] == 4'b0000))
		else $error("warm band T2 out of range");

endmodule

// ===== verif/baro_comp_checker.sv =====
`timescale 1ns / 1ps

// Watches the sample, result and calibration channels of the compensation
// block. It predicts each result from its own copy of the calibration words
// and compares it with what the block delivers.
module baro_comp_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	input  logic                                 sample_stall,
	input  logic [bptc_pkg::RAW_W-1:0]           raw_pressure,
	input  logic [bptc_pkg::RAW_W-1:0]           raw_temperature,
	input  logic                                 result_valid,
	input  logic                                 result_stall,
	input  logic signed [bptc_pkg::TEMP_W-1:0]   temperature_centi,
	input  logic signed [bptc_pkg::PRES_W-1:0]   pressure_centi_mbar,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [bptc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bptc_pkg::COEFF_W-1:0]         cfg_data,
	output int                                   fail_count,
	output int                                   pending_count
);
	import bptc_pkg::*;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_centi;
		logic signed [PRES_W-1:0] pres_centi;
	} reading_t;

	coeffs_t  cal = '0;
	reading_t readings_due[$];
	reading_t want;
	int       n_fail = 0;
	int       n_pending = 0;

	assign fail_count    = n_fail;
	assign pending_count = n_pending;

	// Second-order compensation of one raw pair, exact in 64 bits.
	// >>> on a signed longint rounds toward minus infinity.
	function automatic reading_t compensate(coeffs_t c, logic [RAW_W-1:0] d1_raw,
			logic [RAW_W-1:0] d2_raw);
		longint c1, c2, c3, c4, c5, c6;
		longint d1, d2, dt, temp, t2, off2, sens2, off, sens, p, lo, hi, tc;
		reading_t r;
		c1 = {48'd0, c.psens};
		c2 = {48'd0, c.poff};
		c3 = {48'd0, c.tcs};
		c4 = {48'd0, c.tco};
		c5 = {48'd0, c.tref};
		c6 = {48'd0, c.tempsens};
		d1 = {40'd0, d1_raw};
		d2 = {40'd0, d2_raw};

		dt   = d2 - c5 * 256;
		temp = 2000 + ((dt * c6) >>> 23);

		if (temp < 2000) begin
			// below 20 C, with an extra term below -15 C
			lo    = temp - 2000;
			t2    = (3 * dt * dt) >>> 33;
			off2  = (61 * lo * lo) / 16;
			sens2 = (29 * lo * lo) / 16;
			if (temp < -1500) begin
				hi    = temp + 1500;
				off2  = off2 + 17 * hi * hi;
				sens2 = sens2 + 9 * hi * hi;
			end
		end else begin
			t2    = (5 * dt * dt) >>> 38;
			off2  = 0;
			sens2 = 0;
		end

		off  = c2 * 65536 + ((c4 * dt) >>> 7) - off2;
		sens = c1 * 32768 + ((c3 * dt) >>> 8) - sens2;
		p    = (((d1 * sens) >>> 21) - off) >>> 15;

		tc = temp - t2;
		r.temp_centi = tc[TEMP_W-1:0];
		r.pres_centi = p[PRES_W-1:0];
		return r;
	endfunction

	// Monitor: result check first, then new sample, then calibration write
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal = '0;
		end else begin
			if (result_valid && !result_stall) begin
				if (readings_due.size() == 0) begin
					$error("result transfer with nothing pending: temp %0d pres %0d",
						temperature_centi, pressure_centi_mbar);
					n_fail++;
				end else begin
					want = readings_due.pop_front();
					if (temperature_centi !== want.temp_centi) begin
						$error("temperature_centi: expected %0d, actual %0d",
							want.temp_centi, temperature_centi);
						n_fail++;
					end
					if (pressure_centi_mbar !== want.pres_centi) begin
						$error("pressure_centi_mbar: expected %0d, actual %0d",
							want.pres_centi, pressure_centi_mbar);
						n_fail++;
					end
				end
			end

			if (sample_valid && !sample_stall)
				readings_due.push_back(compensate(cal, raw_pressure, raw_temperature));

			// unknown indexes leave the calibration alone
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PSENS:    cal.psens    = cfg_data;
					CFG_POFF:     cal.poff     = cfg_data;
					CFG_TCS:      cal.tcs      = cfg_data;
					CFG_TCO:      cal.tco      = cfg_data;
					CFG_TREF:     cal.tref     = cfg_data;
					CFG_TEMPSENS: cal.tempsens = cfg_data;
					default: ;
				endcase
			end

			n_pending = readings_due.size();
		end
	end

endmodule

// ===== verif/baro_pressure_temp_compensation_test.sv =====
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_test;
	import bptc_pkg::*;

	localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 118;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       sample_valid;
	logic                       sample_stall;
	logic [RAW_W-1:0]           raw_pressure;
	logic [RAW_W-1:0]           raw_temperature;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [TEMP_W-1:0]   temperature_centi;
	logic signed [PRES_W-1:0]   pressure_centi_mbar;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [COEFF_W-1:0]         cfg_data;

	int      fail_count;
	int      pending_count;
	int      gap_pct = 18;
	int      stall_pct = 18;
	int      quiet_cycles = 0;
	coeffs_t cal_now = '0;
	coeffs_t typical_cal;

	always #5 clk = ~clk;

	baro_pressure_temp_compensation u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.sample_valid        (sample_valid),
		.sample_stall        (sample_stall),
		.raw_pressure        (raw_pressure),
		.raw_temperature     (raw_temperature),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.temperature_centi   (temperature_centi),
		.pressure_centi_mbar (pressure_centi_mbar),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	baro_comp_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.sample_valid        (sample_valid),
		.sample_stall        (sample_stall),
		.raw_pressure        (raw_pressure),
		.raw_temperature     (raw_temperature),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.temperature_centi   (temperature_centi),
		.pressure_centi_mbar (pressure_centi_mbar),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.fail_count          (fail_count),
		.pending_count       (pending_count)
	);

	// Random backpressure on the result side
	always @(negedge clk) begin
		result_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Watchdog: too long without any transfer ends the run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// One calibration register write; called and returns at a falling edge
	task automatic write_coeff(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] data);
		logic took;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do begin
			@(posedge clk);
			took = cfg_ready;
			@(negedge clk);
		end while (!took);
		cfg_valid = 1'b0;
	endtask

	task automatic load_cal(coeffs_t c);
		write_coeff(CFG_PSENS, c.psens);
		write_coeff(CFG_POFF, c.poff);
		write_coeff(CFG_TCS, c.tcs);
		write_coeff(CFG_TCO, c.tco);
		write_coeff(CFG_TREF, c.tref);
		write_coeff(CFG_TEMPSENS, c.tempsens);
		cal_now = c;
	endtask

	// One raw pair, with random idle cycles in front
	task automatic feed_pair(logic [RAW_W-1:0] d1, logic [RAW_W-1:0] d2);
		logic took;
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_valid    = 1'b1;
		raw_pressure    = d1;
		raw_temperature = d2;
		do begin
			@(posedge clk);
			took = !sample_stall;
			@(negedge clk);
		end while (!took);
		sample_valid = 1'b0;
	endtask

	// Temperature is steered around the reference point in four of ten draws
	task automatic feed_random();
		int d2_near;
		int span;
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
		case ($urandom_range(9))
			0:       d1 = '0;
			1:       d1 = RAW_MAX;
			default: d1 = RAW_W'($urandom_range(RAW_MAX));
		endcase
		case ($urandom_range(9))
			0: d2 = '0;
			1: d2 = RAW_MAX;
			2, 3, 4, 5: begin
				span = int'($urandom_range(21));
				d2_near = int'(cal_now.tref) * 256 +
					int'($urandom_range(1 << (span + 1))) - (1 << span);
				if (d2_near < 0)
					d2_near = 0;
				else if (d2_near > int'(RAW_MAX))
					d2_near = int'(RAW_MAX);
				d2 = d2_near[RAW_W-1:0];
			end
			default: d2 = RAW_W'($urandom_range(RAW_MAX));
		endcase
		feed_pair(d1, d2);
	endtask

	function automatic logic [COEFF_W-1:0] pick_coeff(logic [COEFF_W-1:0] typ);
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			2, 3:    return typ ^ COEFF_W'($urandom_range(255));
			default: return COEFF_W'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic drain();
		while (pending_count != 0)
			@(negedge clk);
	endtask

	initial begin
		coeffs_t c;
		arst_n          = 1'b0;
		sample_valid    = 1'b0;
		raw_pressure    = '0;
		raw_temperature = '0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_PSENS;
		cfg_data        = '0;
		typical_cal     = '{psens: 16'd40127, poff: 16'd36924, tcs: 16'd23317,
			tco: 16'd23282, tref: 16'd33464, tempsens: 16'd28312};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// uncalibrated: coefficients still at reset
		feed_pair('0, '0);
		feed_pair(RAW_MAX, RAW_MAX);
		feed_pair(RAW_MAX, '0);
		drain();

		// typical calibration: reference point at raw 8566784
		load_cal(typical_cal);
		feed_pair(24'd9085466, 24'd8569150);
		feed_pair('0, 24'd8569150);
		feed_pair(RAW_MAX, 24'd8569150);
		feed_pair(24'd9085466, 24'd8566784);    // exactly 20 C
		feed_pair(24'd9085466, 24'd8566783);    // just below 20 C
		feed_pair(24'd9085466, 24'd7529764);    // exactly -15 C
		feed_pair(24'd9085466, 24'd7529763);    // just below -15 C
		feed_pair(RAW_MAX, '0);                 // coldest
		feed_pair('0, '0);
		feed_pair(RAW_MAX, RAW_MAX);            // hottest
		feed_pair('0, RAW_MAX);
		feed_pair(24'h555555, 24'hAAAAAA);
		feed_pair(24'hAAAAAA, 24'h555555);
		drain();

		// random phases over several calibrations
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: c = '1;
				1: c = '0;
				2: c = typical_cal;
				default: begin
					c.psens    = pick_coeff(typical_cal.psens);
					c.poff     = pick_coeff(typical_cal.poff);
					c.tcs      = pick_coeff(typical_cal.tcs);
					c.tco      = pick_coeff(typical_cal.tco);
					c.tref     = pick_coeff(typical_cal.tref);
					c.tempsens = pick_coeff(typical_cal.tempsens);
				end
			endcase
			load_cal(c);
			if (ph == 3) begin
				// writes to unused indexes must not disturb anything
				write_coeff(CFG_SPARE_LO, COEFF_W'($urandom_range(16'hFFFF)));
				write_coeff(CFG_SPARE_HI, COEFF_W'($urandom_range(16'hFFFF)));
			end
			// phase 2 is a full-rate stretch with no idling on either side
			gap_pct   = (ph == 2) ? 0 : 18;
			stall_pct = (ph == 2) ? 0 : 18;
			repeat (PHASE_ITEMS) feed_random();
			drain();
		end

		stall_pct = 0;
		repeat (20) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/bptc_pkg.sv
rtl/core/bptc_cfg_regs.sv
rtl/core/baro_pressure_temp_compensation.sv
verif/baro_comp_checker.sv
verif/baro_pressure_temp_compensation_test.sv
